/* hw/rtl/wca_pkg.sv */
// shared types and constants for the waveform covariance accumulator
// no dependencies; imported by every module of the block
package wca_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLES     = 16;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int ROW_W       = $clog2(SAMPLES);
  localparam int ST_AW       = CH_W + ROW_W;
  localparam int CR_AW       = CH_W + 2 * ROW_W;
  localparam int CR_DEPTH    = 1 << CR_AW;
  localparam int ST_DEPTH    = 1 << ST_AW;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CW      = $clog2(DIV_STEPS);

  typedef enum logic {
    REG_SCALE   = 1'b0,
    REG_SAMPLES = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    FUNC_ACC  = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef struct packed {
    logic               func;
    logic [1:0]         channel;
    logic [3:0]         position;
    logic signed [15:0] sample_value;
    logic [3:0]         col_position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] mean_sum;
    logic signed [31:0] square_sum;
    logic signed [31:0] cross_sum;
    logic [31:0]        spike_count;
  } res_t;

  // classified command handed from front to back
  typedef struct packed {
    logic               is_read;
    logic               acc_ok;
    logic               last;
    logic               ch_ok;
    logic               row_ok;
    logic               pair_ok;
    logic [1:0]         ch;
    logic [3:0]         pos;
    logic [3:0]         r0;
    logic [3:0]         r1;
    logic signed [15:0] x;
    logic [15:0]        s;
    logic [31:0]        ss;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] mag;
    logic [31:0] den;
    logic        neg;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FETCH,
    ST_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    PH_MEAN,
    PH_SQUARE,
    PH_CROSS
  } phase_e;

endpackage

/* hw/rtl/wca_front.sv */
// front end: configuration registers and request classification
// depends on wca_pkg
module wca_front import wca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  req_t        req_i,
  output cmd_t        cmd_o
);

  logic [15:0] scale_q;
  logic [4:0]  samples_q;
  logic [15:0] s_eff;
  logic [4:0]  n_eff;
  logic        swap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= 16'd1;
      samples_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SCALE:   scale_q   <= cfg_data_i;
        REG_SAMPLES: samples_q <= cfg_data_i[4:0];
        default:     scale_q   <= scale_q;
      endcase
    end
  end

  always_comb begin
    s_eff = (scale_q == 16'd0) ? 16'd1 : scale_q;
    if (samples_q == 5'd0) begin
      n_eff = 5'd1;
    end else if (int'(samples_q) > SAMPLES) begin
      n_eff = 5'(SAMPLES);
    end else begin
      n_eff = samples_q;
    end
    swap          = req_i.position > req_i.col_position;
    cmd_o.is_read = (req_i.func == FUNC_READ);
    cmd_o.ch_ok   = int'(req_i.channel) < CHANNELS;
    cmd_o.acc_ok  = cmd_o.ch_ok && ({1'b0, req_i.position} < n_eff);
    cmd_o.last    = ({1'b0, req_i.position} == n_eff - 5'd1);
    cmd_o.row_ok  = int'(req_i.position) < SAMPLES;
    cmd_o.ch      = req_i.channel;
    cmd_o.pos     = req_i.position;
    if (cmd_o.is_read) begin
      cmd_o.r0 = swap ? req_i.col_position : req_i.position;
      cmd_o.r1 = swap ? req_i.position : req_i.col_position;
    end else begin
      cmd_o.r0 = req_i.position;
      cmd_o.r1 = req_i.position;
    end
    cmd_o.pair_ok = (int'(cmd_o.r0) < SAMPLES) && (int'(cmd_o.r1) < SAMPLES);
    cmd_o.x       = req_i.sample_value;
    cmd_o.s       = s_eff;
    cmd_o.ss      = s_eff * s_eff;
  end

endmodule

/* hw/rtl/wca_fifo.sv */
// short command queue between front and back
// depends on wca_pkg
module wca_fifo import wca_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_q, rd_q;
  logic [Q_AW:0]   cnt_q;

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (int'(cnt_q) == QUEUE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (int'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (int'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (Q_AW + 1)'(push_i) - (Q_AW + 1)'(pop_i);
    end
  end

endmodule

/* hw/rtl/wca_div.sv */
// restoring divider, one quotient bit per cycle, sign applied at the end
// depends on wca_pkg
module wca_div import wca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [32:0]       rem_q, rem_sh;
  logic [31:0]       quo_q, den_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              run_q, done_q, neg_q;

  assign rem_sh     = {rem_q[31:0], quo_q[31]};
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.mag;
      den_q <= req_i.den;
      neg_q <= req_i.neg;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // pulse after the last quotient bit
      done_q <= !req_i.start && run_q && (int'(cnt_q) == DIV_STEPS - 1);
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (int'(cnt_q) == DIV_STEPS - 1) begin
          run_q <= 1'b0;
        end
      end
    end
  end

endmodule

/* hw/rtl/wca_back.sv */
// back end: sequencer, statistic memories, spike counters, result register
// depends on wca_pkg; instantiates nothing, talks to wca_div by structs
module wca_back import wca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  cmd_t     cmd_i,
  output logic     pop_o,
  output logic     clearing_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  output logic     done_o,
  output res_t     res_o
);

  back_state_e state_q, state_d;
  phase_e      phase_q;
  cmd_t        cmd_q;
  logic [ROW_W-1:0]   row_q;
  logic [CR_AW-1:0]   clr_q;
  logic signed [15:0] wave_q [SAMPLES];
  logic [31:0]        count_q [CHANNELS];
  logic signed [31:0] prod_q;
  logic [31:0]        den_q;

  logic [31:0] mean_mem [ST_DEPTH];
  logic [31:0] sq_mem   [ST_DEPTH];
  logic [31:0] cr_mem   [CR_DEPTH];
  logic [31:0] mean_rd_q, sq_rd_q, cr_rd_q;

  logic [ST_AW-1:0] st_addr, st_waddr;
  logic [CR_AW-1:0] cr_raddr, cr_racc, cr_waddr;
  logic             mean_we, sq_we, cr_we, upd;
  logic [31:0]      mean_wd, sq_wd, cr_wd;
  logic signed [15:0] opnd;
  logic             done_q;
  res_t             res_q;

  assign st_addr  = {cmd_q.ch[CH_W-1:0], cmd_q.pos[ROW_W-1:0]};
  assign cr_racc  = {cmd_q.ch[CH_W-1:0], row_q, cmd_q.pos[ROW_W-1:0]};
  assign cr_raddr = (state_q == ST_FETCH) ?
                    {cmd_q.ch[CH_W-1:0], cmd_q.r0[ROW_W-1:0], cmd_q.r1[ROW_W-1:0]} : cr_racc;
  assign upd      = (state_q == ST_DIV_WAIT) && div_rsp_i.done;
  assign done_o   = done_q;
  assign res_o    = res_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (&clr_q) state_d = ST_IDLE;
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = (cmd_i.is_read || !cmd_i.acc_ok) ? ST_FETCH : ST_MUL;
        end
      end
      ST_MUL:      state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = (phase_q == PH_CROSS && row_q == cmd_q.pos[ROW_W-1:0]) ?
                    ST_FETCH : ST_MUL;
        end
      end
      ST_FETCH:    state_d = ST_OUT;
      ST_OUT:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    clearing_o      = (state_q == ST_CLEAR);
    pop_o           = (state_q == ST_IDLE) && !empty_i;
    div_req_o.start = (state_q == ST_DIV_GO);
    div_req_o.mag   = prod_q[31] ? 32'(-prod_q) : 32'(prod_q);
    div_req_o.den   = den_q;
    div_req_o.neg   = prod_q[31];
    mean_we  = clearing_o || (upd && phase_q == PH_MEAN);
    sq_we    = clearing_o || (upd && phase_q == PH_SQUARE);
    cr_we    = clearing_o || (upd && phase_q == PH_CROSS);
    st_waddr = clearing_o ? clr_q[ST_AW-1:0] : st_addr;
    cr_waddr = clearing_o ? clr_q : cr_racc;
    mean_wd  = clearing_o ? '0 : mean_rd_q + div_rsp_i.quo;
    sq_wd    = clearing_o ? '0 : sq_rd_q + div_rsp_i.quo;
    cr_wd    = clearing_o ? '0 : cr_rd_q + div_rsp_i.quo;
    unique case (phase_q)
      PH_MEAN:   opnd = 16'sd1;
      PH_SQUARE: opnd = cmd_q.x;
      default:   opnd = wave_q[row_q];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mean_we) mean_mem[st_waddr] <= mean_wd;
    if (sq_we)   sq_mem[st_waddr]   <= sq_wd;
    if (cr_we)   cr_mem[cr_waddr]   <= cr_wd;
    mean_rd_q <= mean_mem[st_addr];
    sq_rd_q   <= sq_mem[st_addr];
    cr_rd_q   <= cr_mem[cr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
      if (!cmd_i.is_read && cmd_i.acc_ok) begin
        wave_q[cmd_i.pos[ROW_W-1:0]] <= cmd_i.x;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= cmd_q.x * opnd;
      den_q  <= (phase_q == PH_MEAN) ? {16'd0, cmd_q.s} : cmd_q.ss;
    end
    if (state_q == ST_OUT) begin
      res_q.mean_sum    <= (cmd_q.ch_ok && cmd_q.row_ok) ? mean_rd_q : '0;
      res_q.square_sum  <= (cmd_q.ch_ok && cmd_q.row_ok) ? sq_rd_q : '0;
      res_q.cross_sum   <= (cmd_q.ch_ok && cmd_q.pair_ok) ? cr_rd_q : '0;
      res_q.spike_count <= cmd_q.ch_ok ? count_q[cmd_q.ch[CH_W-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      phase_q <= PH_MEAN;
      row_q   <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) count_q[i] <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_OUT);
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (pop_o) begin
        phase_q <= PH_MEAN;
        row_q   <= '0;
      end
      if (upd) begin
        unique case (phase_q)
          PH_MEAN:   phase_q <= PH_SQUARE;
          PH_SQUARE: phase_q <= PH_CROSS;
          default: begin
            if (row_q == cmd_q.pos[ROW_W-1:0]) begin
              if (cmd_q.last) begin
                count_q[cmd_q.ch[CH_W-1:0]] <= count_q[cmd_q.ch[CH_W-1:0]] + 32'd1;
              end
            end else begin
              row_q <= row_q + 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

/* hw/rtl/waveform_covariance_accumulator.sv */
// top level of the waveform covariance accumulator
// depends on wca_pkg; instantiates wca_front, wca_fifo, wca_div and wca_back
//
// usage
// - a request is taken at a rising edge with start_i high and busy_o low;
//   req_i.func selects accumulate (one sample) or read (statistics of a pair)
// - every request yields exactly one result on res_o, marked by done_o for
//   a single cycle; the receiver cannot stall, so results never wait
// - configuration (scale divisor, samples in use) is written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle
// - a two-entry queue sits between the front end and the sequencer, so
//   outside the reset sweep busy_o rises only when that queue is full
// - an accumulate at a position p within the spike length runs (p + 3)
//   divisions on the bit-serial divider before its result; a read and an
//   accumulate outside the spike length only fetch and output
// - after reset the statistic memories are swept to zero, one cross entry
//   a cycle over all 1024 entries, with busy_o high; config writes still land
// - sums wrap at 32 bits, divisions truncate toward zero
module waveform_covariance_accumulator import wca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        done_o,
  output res_t        res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t     front_cmd, head_cmd;
  logic     push, pop, empty, full, clearing;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // request taken only while the queue has room and the sweep is over
  assign busy_o = full || clearing;
  assign push   = start_i && !busy_o;

  // classification and config registers
  wca_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .req_i,
    .cmd_o (front_cmd)
  );

  // decouples the front end from the sequencer
  wca_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (front_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  // shared divider for mean, square and cross terms
  wca_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // sequencer with memories and result register
  wca_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i    (empty),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .clearing_o (clearing),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .done_o,
    .res_o
  );

endmodule

/* tb/sv/tb_waveform_covariance_accumulator.sv */
// self-checking testbench for the waveform covariance accumulator
// depends on wca_pkg and waveform_covariance_accumulator; standalone, no files read
`timescale 1ns / 1ps

module tb_waveform_covariance_accumulator;
  import wca_pkg::*;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start_i    = 1'b0;
  logic        busy_o;
  req_t        req_i      = '0;
  logic        done_o;
  res_t        res_o;
  logic        cfg_we_i   = 1'b0;
  logic        cfg_idx_i  = 1'b0;
  logic [15:0] cfg_data_i = '0;

  waveform_covariance_accumulator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the block's statistics, kept in step with every accepted request
  logic [15:0]  shd_scale;
  logic [4:0]   shd_nuse;
  longint       shd_wave [SAMPLES];
  logic [31:0]  shd_mean [CHANNELS*SAMPLES];
  logic [31:0]  shd_square [CHANNELS*SAMPLES];
  logic [31:0]  shd_cross [CHANNELS*SAMPLES*SAMPLES];
  logic [31:0]  shd_count [CHANNELS];

  res_t pending_stats [$];
  int   mismatches   = 0;
  int   results_seen = 0;
  int   acc_sent     = 0;
  int   read_sent    = 0;
  int   ignored_sent = 0;
  int   burst_left   = 0;
  bit   gaps_on      = 1'b1;

  function automatic int unsigned eff_samples();
    if (shd_nuse == 0) return 1;
    if (shd_nuse > SAMPLES) return SAMPLES;
    return shd_nuse;
  endfunction

  // apply one request to the shadow and return the statistics it should report
  function automatic res_t update_stats(req_t r);
    longint      s, ss, x;
    int unsigned n, base, r0, r1, row, idx;
    res_t        o;
    s    = (shd_scale == 0) ? 1 : longint'(shd_scale);
    ss   = s * s;
    x    = longint'(r.sample_value);
    n    = eff_samples();
    base = r.channel * SAMPLES;
    if (r.func == FUNC_ACC) begin
      if (r.position < n) begin
        shd_wave[r.position] = x;
        shd_mean[base + r.position]   += 32'(x / s);
        shd_square[base + r.position] += 32'((x * x) / ss);
        for (row = 0; row <= r.position; row++) begin
          idx = (base + row) * SAMPLES + r.position;
          shd_cross[idx] += 32'((shd_wave[row] * x) / ss);
        end
        if (r.position == n - 1) shd_count[r.channel] += 1;
      end
      r0 = r.position;
      r1 = r.position;
    end else begin
      r0 = (r.position < r.col_position) ? r.position : r.col_position;
      r1 = (r.position < r.col_position) ? r.col_position : r.position;
    end
    o.mean_sum    = shd_mean[base + r.position];
    o.square_sum  = shd_square[base + r.position];
    o.cross_sum   = shd_cross[(base + r0) * SAMPLES + r1];
    o.spike_count = shd_count[r.channel];
    return o;
  endfunction

  // result checker: one result per done_o, compared against the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding: %p", res_o);
      end else begin
        want = pending_stats.pop_front();
        if (res_o.mean_sum !== want.mean_sum || res_o.square_sum !== want.square_sum ||
            res_o.cross_sum !== want.cross_sum || res_o.spike_count !== want.spike_count)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mean %0d sq %0d cross %0d cnt %0d, got %0d %0d %0d %0d",
                     want.mean_sum, want.square_sum, want.cross_sum, want.spike_count,
                     res_o.mean_sum, res_o.square_sum, res_o.cross_sum, res_o.spike_count);
        end
      end
    end
  end

  // present one request and hold it until accepted; start stays high across bursts
  task automatic issue(req_t r, bit typed, res_t typed_res);
    res_t p;
    if (gaps_on && burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    p = update_stats(r);
    pending_stats.push_back(typed ? typed_res : p);
    if (burst_left > 0) burst_left--;
    if (r.func == FUNC_READ) read_sent++;
    else if (r.position < eff_samples()) acc_sent++;
    else ignored_sent++;
  endtask

  task automatic quiesce();
    start_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SCALE) shd_scale = val;
    else shd_nuse = val[4:0];
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t mk_req(func_e f, int ch, int pos, logic [15:0] x, int col);
    req_t r;
    r.func         = f;
    r.channel      = 2'(ch);
    r.position     = 4'(pos);
    r.sample_value = x;
    r.col_position = 4'(col);
    return r;
  endfunction

  // random traffic: mostly whole spikes in position order, with reads and stray samples
  task automatic random_phase(int n_items);
    int   done_items, kind, ch, p, n;
    req_t r;
    res_t none;
    done_items = 0;
    none = '0;
    n = eff_samples();
    while (done_items < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        ch = $urandom_range(0, CHANNELS - 1);
        for (p = 0; p < n; p++) begin
          issue(mk_req(FUNC_ACC, ch, p, pick_sample(), $urandom_range(0, 15)), 0, none);
          done_items++;
          if ($urandom_range(0, 5) == 0) begin
            issue(mk_req(FUNC_READ, ch, $urandom_range(0, 15), 16'($urandom),
                         $urandom_range(0, 15)), 0, none);
            done_items++;
          end
        end
      end else if (kind <= 8) begin
        issue(mk_req(FUNC_READ, $urandom_range(0, 3), $urandom_range(0, 15), 16'($urandom),
                     $urandom_range(0, 15)), 0, none);
        done_items++;
      end else begin
        // stray sample anywhere, including positions past the spike length
        r = mk_req(FUNC_ACC, $urandom_range(0, 3), $urandom_range(0, 15), pick_sample(),
                   $urandom_range(0, 15));
        if (r.position < n) done_items++;
        issue(r, 0, none);
      end
    end
  endtask

  typedef struct {
    req_t r;
    bit   typed;
    res_t want;
  } stim_row_t;

  stim_row_t stim_rows [$];

  initial begin
    stim_row_t row;
    res_t      z;
    int        i;
    z = '0;
    shd_scale = 16'd1;
    shd_nuse  = 5'd16;
    foreach (shd_wave[k]) shd_wave[k] = 0;
    foreach (shd_mean[k]) shd_mean[k] = '0;
    foreach (shd_square[k]) shd_square[k] = '0;
    foreach (shd_cross[k]) shd_cross[k] = '0;
    foreach (shd_count[k]) shd_count[k] = '0;

    // directed table; a full first spike writes every buffer row before anything reads it
    stim_rows.push_back('{mk_req(FUNC_READ, 3, 15, 16'h0, 0), 1, z});   // clean after reset
    row.r = mk_req(FUNC_ACC, 0, 0, 16'h8000, 15);                       // most negative sample
    row.typed = 1;
    row.want = '{-32'sd32768, 32'sd1073741824, 32'sd1073741824, 32'd0};
    stim_rows.push_back(row);
    stim_rows.push_back('{mk_req(FUNC_ACC, 0, 1, 16'h7fff, 0), 0, z});  // most positive
    for (i = 2; i < 15; i++)
      stim_rows.push_back('{mk_req(FUNC_ACC, 0, i, 16'(i * 1237 - 9000), 0), 0, z});
    stim_rows.push_back('{mk_req(FUNC_ACC, 0, 15, 16'hffff, 0), 0, z}); // closes the spike
    stim_rows.push_back('{mk_req(FUNC_READ, 0, 15, 16'h0, 0), 0, z});   // swapped pair
    stim_rows.push_back('{mk_req(FUNC_READ, 0, 3, 16'hffff, 3), 0, z}); // diagonal
    stim_rows.push_back('{mk_req(FUNC_READ, 0, 0, 16'h0, 15), 0, z});   // corner pair
    stim_rows.push_back('{mk_req(FUNC_READ, 1, 2, 16'h0, 9), 1, z});    // untouched channel

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_cfg(REG_SCALE, 16'd1);
    write_cfg(REG_SAMPLES, 16'd16);

    foreach (stim_rows[k]) issue(stim_rows[k].r, stim_rows[k].typed, stim_rows[k].want);
    // sender holds off until the block has drained every result
    quiesce();

    random_phase(130);
    quiesce();
    // zero divisor acts as one, zero length acts as a single position
    write_cfg(REG_SCALE, 16'd0);
    write_cfg(REG_SAMPLES, 16'd0);
    random_phase(90);
    quiesce();
    // largest divisor, length above the buffer clamps to full
    write_cfg(REG_SCALE, 16'hffff);
    write_cfg(REG_SAMPLES, 16'd31);
    gaps_on = 1'b0;
    random_phase(110);
    quiesce();
    gaps_on = 1'b1;
    write_cfg(REG_SCALE, 16'd3);
    write_cfg(REG_SAMPLES, 16'd5);
    random_phase(140);
    quiesce();
    write_cfg(REG_SCALE, 16'd181);
    write_cfg(REG_SAMPLES, 16'd17);
    random_phase(110);
    quiesce();
    write_cfg(REG_SCALE, 16'd7);
    write_cfg(REG_SAMPLES, 16'd9);
    gaps_on = 1'b0;
    random_phase(60);
    gaps_on = 1'b1;
    random_phase(60);

    start_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);

    $display("covered %0d accumulates, %0d reads, %0d ignored samples, %0d results checked",
             acc_sent, read_sent, ignored_sent, results_seen);
    $display("divisors 0..65535 and spike lengths 0..31 exercised across six settings");
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_stats.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_stats.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
